// ===== rtl/mm3_pkg.sv =====
// ---------------------------------------------------------------------------
// mm3_pkg
// Shared constants, command and status types and rotate helpers for the byte-serial
// 32-bit murmur3 hash core.
// ---------------------------------------------------------------------------
package mm3_pkg;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] NK = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MUL_C1,
		OP_TAIL_C1,
		OP_MUL_C2,
		OP_HASH_UPD,
		OP_FIN_XOR,
		OP_MUL_F1,
		OP_MUL_F2,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   cfg_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] pos;
		logic       has_tail;
		logic       out_busy;
		logic       fresh;
	} dp_stat_t;

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

endpackage

// ===== rtl/murmur3_32_stream_hash_core.sv =====
// ---------------------------------------------------------------------------
// murmur3_32_stream_hash_core
// 32-bit murmur3 of a key streamed one byte per word, seed register.
// ---------------------------------------------------------------------------
// a byte word is taken while the sequencer is idle; a byte that completes a
// 32-bit block holds off input through the block mix (C1 and C2 multiplies
// in the single shared multiplier, then the hash update); a last word then
// runs the tail mix, final xor and avalanche into the result register
// a new byte word is taken while a result waits; the next result waits for it
// reset: asynchronous, seed 0, empty key, no result pending
module murmur3_32_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value,
	output logic [31:0] key_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] seed
);

	mm3_pkg::dp_cmd_t  cmd;
	mm3_pkg::dp_stat_t stat;

	mm3_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_valid (byte_valid),
		.last_item  (last_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mm3_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.seed       (seed),
		.out_ready  (out_ready),
		.stat       (stat),
		.out_valid  (out_valid),
		.hash_value (hash_value),
		.key_length (key_length)
	);

	// a seed write leaves a clean key
	a_cfg_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> stat.fresh)
		else $error("key state not cleared after seed write");

	// a byte that does not close a block advances the position by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && byte_valid && !last_item && (stat.pos != 2'd3))
		|=> (stat.pos == ($past(stat.pos) + 2'd1)))
		else $error("byte position did not advance");

	// a result only appears after the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == mm3_pkg::OP_EMIT))
		else $error("result raised without emit");

	// config and data words are never taken together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && cfg_valid && cfg_ready))
		else $error("config and data accepted in one cycle");

endmodule

// ===== rtl/mm3_datapath.sv =====
// ---------------------------------------------------------------------------
// mm3_datapath
// Key state, byte packing, one shared 32x32 multiplier and the result
// register of the murmur3 core.
// ---------------------------------------------------------------------------
module mm3_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  mm3_pkg::dp_cmd_t  cmd,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic [31:0]       seed,
	input  logic              out_ready,
	output mm3_pkg::dp_stat_t stat,
	output logic              out_valid,
	output logic [31:0]       hash_value,
	output logic [31:0]       key_length
);

	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] acc_q;
	logic [1:0]  pos_q;
	logic [31:0] cnt_q;
	logic [31:0] k_q;
	logic        out_valid_q;
	logic [31:0] hash_out_q;
	logic [31:0] len_out_q;

	logic [31:0] acc_ins;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] hx;
	logic [31:0] hash_upd;
	logic [31:0] fx;
	logic        take_byte;

	assign take_byte = (cmd.op == mm3_pkg::OP_ACCEPT) && byte_valid;
	assign acc_ins   = acc_q | ({24'd0, data_byte} << {pos_q, 3'b000});

	// shared multiplier, operand picked by the current step
	always_comb begin
		mul_a = k_q;
		mul_b = mm3_pkg::C1;
		unique case (cmd.op)
			mm3_pkg::OP_TAIL_C1: begin
				mul_a = acc_q;
				mul_b = mm3_pkg::C1;
			end
			mm3_pkg::OP_MUL_C2: begin
				mul_a = mm3_pkg::rotl15(k_q);
				mul_b = mm3_pkg::C2;
			end
			mm3_pkg::OP_MUL_F1: begin
				mul_a = k_q;
				mul_b = mm3_pkg::F1;
			end
			mm3_pkg::OP_MUL_F2: begin
				mul_a = k_q ^ (k_q >> 13);
				mul_b = mm3_pkg::F2;
			end
			default: begin
				mul_a = k_q;
				mul_b = mm3_pkg::C1;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign hx       = mm3_pkg::rotl13(hash_q ^ k_q);
	// h * 5 + n as shift and add
	assign hash_upd = (hx << 2) + hx + mm3_pkg::NK;
	assign fx       = hash_q ^ ((pos_q != 2'd0) ? k_q : 32'd0) ^ cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			hash_q      <= '0;
			acc_q       <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			hash_out_q  <= '0;
			len_out_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && (cmd.op != mm3_pkg::OP_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.cfg_load) begin
				seed_q <= seed;
				hash_q <= seed;
				acc_q  <= '0;
				pos_q  <= '0;
				cnt_q  <= '0;
			end else begin
				unique case (cmd.op)
					mm3_pkg::OP_ACCEPT: begin
						if (take_byte) begin
							cnt_q <= cnt_q + 32'd1;
							pos_q <= pos_q + 2'd1;
							if (pos_q == 2'd3) begin
								k_q   <= acc_ins;
								acc_q <= '0;
							end else begin
								acc_q <= acc_ins;
							end
						end
					end
					mm3_pkg::OP_MUL_C1,
					mm3_pkg::OP_TAIL_C1,
					mm3_pkg::OP_MUL_C2,
					mm3_pkg::OP_MUL_F1,
					mm3_pkg::OP_MUL_F2: begin
						k_q <= mul_p;
					end
					mm3_pkg::OP_HASH_UPD: begin
						hash_q <= hash_upd;
					end
					mm3_pkg::OP_FIN_XOR: begin
						k_q <= fx ^ (fx >> 16);
					end
					mm3_pkg::OP_EMIT: begin
						hash_out_q  <= k_q ^ (k_q >> 16);
						len_out_q   <= cnt_q;
						out_valid_q <= 1'b1;
						hash_q      <= seed_q;
						acc_q       <= '0;
						pos_q       <= '0;
						cnt_q       <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign stat.pos      = pos_q;
	assign stat.has_tail = (pos_q != 2'd0);
	assign stat.out_busy = out_valid_q && !out_ready;
	assign stat.fresh    = (hash_q == seed_q) && (cnt_q == 32'd0) && (pos_q == 2'd0)
		&& (acc_q == 32'd0);

	assign out_valid  = out_valid_q;
	assign hash_value = hash_out_q;
	assign key_length = len_out_q;

endmodule

// ===== rtl/mm3_ctrl.sv =====
// ---------------------------------------------------------------------------
// mm3_ctrl
// Sequencer for the murmur3 core: takes words, walks the block mix and
// the finalization steps through the shared multiplier.
// ---------------------------------------------------------------------------
module mm3_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              byte_valid,
	input  logic              last_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  mm3_pkg::dp_stat_t stat,
	output mm3_pkg::dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_MIX1 = 10'b0000000010,
		ST_MIX2 = 10'b0000000100,
		ST_MIX3 = 10'b0000001000,
		ST_TAIL = 10'b0000010000,
		ST_TM2  = 10'b0000100000,
		ST_FX   = 10'b0001000000,
		ST_FM1  = 10'b0010000000,
		ST_FM2  = 10'b0100000000,
		ST_EMIT = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   last_d;
	logic   idle;

	assign idle      = (state_q == ST_IDLE);
	assign cfg_ready = idle;
	assign in_ready  = idle && !cfg_valid;

	always_comb begin
		state_d      = state_q;
		last_d       = last_q;
		cmd.op       = mm3_pkg::OP_NONE;
		cmd.cfg_load = cfg_valid && idle;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = mm3_pkg::OP_ACCEPT;
					last_d = last_item;
					if (byte_valid && (stat.pos == 2'd3)) begin
						state_d = ST_MIX1;
					end else if (last_item) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_MIX1: begin
				cmd.op  = mm3_pkg::OP_MUL_C1;
				state_d = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.op  = mm3_pkg::OP_MUL_C2;
				state_d = ST_MIX3;
			end
			ST_MIX3: begin
				cmd.op  = mm3_pkg::OP_HASH_UPD;
				state_d = last_q ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				if (stat.has_tail) begin
					cmd.op  = mm3_pkg::OP_TAIL_C1;
					state_d = ST_TM2;
				end else begin
					state_d = ST_FX;
				end
			end
			ST_TM2: begin
				cmd.op  = mm3_pkg::OP_MUL_C2;
				state_d = ST_FX;
			end
			ST_FX: begin
				cmd.op  = mm3_pkg::OP_FIN_XOR;
				state_d = ST_FM1;
			end
			ST_FM1: begin
				cmd.op  = mm3_pkg::OP_MUL_F1;
				state_d = ST_FM2;
			end
			ST_FM2: begin
				cmd.op  = mm3_pkg::OP_MUL_F2;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the result register is free
				if (!stat.out_busy) begin
					cmd.op  = mm3_pkg::OP_EMIT;
					last_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
		end
	end

endmodule

// ===== verif/murmur3_32_stream_hash_core_tb.sv =====
// ---------------------------------------------------------------------------
// murmur3_32_stream_hash_core_tb
// Streams keys one byte per word into the hash core under several seeds and
// compares every digest and length against an in-bench murmur3 predictor,
// with random idle cycles on both sides, a long output stall and a drain
// pause.
// ---------------------------------------------------------------------------
module murmur3_32_stream_hash_core_tb;

	localparam logic [31:0] BLK_MUL_A = 32'hcc9e2d51;
	localparam logic [31:0] BLK_MUL_B = 32'h1b873593;
	localparam logic [31:0] HASH_ADD  = 32'he6546b64;
	localparam logic [31:0] AVAL_MUL1 = 32'h85ebca6b;
	localparam logic [31:0] AVAL_MUL2 = 32'hc2b2ae35;
	localparam int          SETTLE_CYCLES = 16;

	typedef struct {
		logic [31:0] hash;
		logic [31:0] len;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash_value;
	logic [31:0] key_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] seed = 32'h0;

	// predictor state
	logic [31:0] m_seed;
	logic [31:0] m_hash;
	logic [31:0] m_acc;
	logic [1:0]  m_pos;
	logic [31:0] m_count;

	digest_t pending_digests[$];

	int  err_count = 0;
	int  words_sent = 0;
	int  digests_seen = 0;
	int  seed_loads = 0;
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;
	int  sink_hold_req = 0;
	int  sink_hold_left = 0;

	murmur3_32_stream_hash_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.key_length (key_length),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed       (seed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("murmur3_32_stream_hash_core_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] block_scramble(input logic [31:0] k);
		logic [31:0] t;
		t = k * BLK_MUL_A;
		t = {t[16:0], t[31:17]};
		return t * BLK_MUL_B;
	endfunction

	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 16);
		t = t * AVAL_MUL1;
		t = t ^ (t >> 13);
		t = t * AVAL_MUL2;
		return t ^ (t >> 16);
	endfunction

	function automatic void restart_key();
		m_hash  = m_seed;
		m_acc   = 32'h0;
		m_pos   = 2'd0;
		m_count = 32'h0;
	endfunction

	function automatic void absorb_word(input logic [7:0] b, input logic bv,
			input logic lst);
		logic [31:0] h;
		digest_t d;
		if (bv) begin
			m_acc   = m_acc | (32'(b) << (8 * m_pos));
			m_count = m_count + 32'd1;
			m_pos   = m_pos + 2'd1;
			if (m_pos == 2'd0) begin
				h      = m_hash ^ block_scramble(m_acc);
				h      = {h[18:0], h[31:19]};
				m_hash = h * 32'd5 + HASH_ADD;
				m_acc  = 32'h0;
			end
		end
		if (lst) begin
			h = m_hash;
			// partial tail is scrambled in without the hash rotate and multiply-add step
			if (m_pos != 2'd0)
				h = h ^ block_scramble(m_acc);
			d.hash = avalanche(h ^ m_count);
			d.len  = m_count;
			pending_digests.insert(pending_digests.size(), d);
			restart_key();
		end
	endfunction

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (sink_hold_req > 0) begin
			sink_hold_left = sink_hold_req;
			sink_hold_req  = 0;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (sink_hold_left > 0) begin
			out_ready <= 1'b0;
			sink_hold_left = sink_hold_left - 1;
		end else if (sink_idle_on && $urandom_range(99) < 24) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endfunction

	always @(posedge clk) begin
		digest_t want;
		if (arst_n && out_valid && out_ready) begin
			digests_seen++;
			if (pending_digests.size() == 0) begin
				flag_error($sformatf("unexpected digest hash=%h len=%0d",
					hash_value, key_length));
			end else begin
				want = pending_digests.pop_front();
				if (hash_value !== want.hash)
					flag_error($sformatf("hash_value exp %h got %h",
						want.hash, hash_value));
				if (key_length !== want.len)
					flag_error($sformatf("key_length exp %0d got %0d",
						want.len, key_length));
			end
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	task automatic push_word(input logic [7:0] b, input logic bv, input logic lst);
		int gap;
		gap = 0;
		if (src_idle_on && $urandom_range(99) < 12)
			gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		byte_valid <= bv;
		last_item  <= lst;
		do @(posedge clk); while (!in_ready);
		absorb_word(b, bv, lst);
		if (bv || lst)
			words_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_digests.size() != 0)
			@(posedge clk);
	endtask

	// block must be idle: no word offered, all digests out, mix pipeline settled
	task automatic load_seed(input logic [31:0] v);
		release_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		seed      <= v;
		do @(posedge clk); while (!cfg_ready);
		m_seed = v;
		restart_key();
		seed_loads++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// key of len random bytes, closed on the last byte or by an empty word
	task automatic send_key(input int len, input bit close_empty);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5)
				push_word(8'($urandom_range(255)), 1'b0, 1'b0);
			push_word(8'($urandom_range(255)), 1'b1, !close_empty && i == len - 1);
		end
		if (close_empty || len == 0)
			push_word(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_empty_key();
		push_word(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_tail_lengths();
		int n;
		int i;
		for (n = 1; n <= 4; n++)
			for (i = 0; i < n; i++)
				push_word((i % 2) ? 8'h00 : 8'hff, 1'b1, i == n - 1);
	endtask

	task automatic test_word_then_close();
		push_word(8'hff, 1'b1, 1'b0);
		push_word(8'h80, 1'b1, 1'b0);
		push_word(8'h01, 1'b1, 1'b0);
		push_word(8'hff, 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_noise_words();
		push_word(8'hff, 1'b0, 1'b0);
		push_word(8'h5a, 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b0);
		push_word(8'ha5, 1'b1, 1'b1);
	endtask

	// seed write in the middle of a key throws the partial key away
	task automatic test_seed_abandons_key();
		push_word(8'h11, 1'b1, 1'b0);
		push_word(8'h22, 1'b1, 1'b0);
		push_word(8'h33, 1'b1, 1'b0);
		load_seed(32'h9e3779b9);
		push_word(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_random_keys(input int n_words);
		int start;
		int len;
		start = words_sent;
		while (words_sent - start < n_words) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			send_key(len, 1'($urandom_range(1)));
		end
	endtask

	task automatic test_output_backpressure();
		int k;
		release_input();
		sink_hold_req = 300;
		for (k = 0; k < 20; k++)
			send_key($urandom_range(0, 3), 1'($urandom_range(1)));
	endtask

	task automatic test_drain_pause();
		int k;
		for (k = 0; k < 4; k++)
			send_key($urandom_range(1, 9), 1'($urandom_range(1)));
		release_input();
		wait_drained();
		for (k = 0; k < 4; k++)
			send_key($urandom_range(1, 9), 1'($urandom_range(1)));
	endtask

	initial begin
		m_seed = 32'h0;
		restart_key();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_key();
		test_tail_lengths();
		test_word_then_close();
		test_noise_words();
		load_seed(32'h0);
		test_seed_abandons_key();

		load_seed(32'hffffffff);
		test_random_keys(200);
		test_output_backpressure();

		load_seed($urandom);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		test_random_keys(200);
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;

		load_seed(32'h80000000);
		test_drain_pause();
		test_random_keys(200);

		load_seed(32'h00000001);
		test_random_keys(120);
		load_seed($urandom);
		test_random_keys(120);

		release_input();
		wait_drained();
		repeat (20) @(posedge clk);

		$display("hashed %0d key words into %0d digests across %0d seed loads,",
			words_sent, digests_seen, seed_loads);
		$display("with input/output stalls, a long output hold and a drain pause");
		if (err_count == 0)
			$display("murmur3_32_stream_hash_core_tb: PASS");
		else
			$display("murmur3_32_stream_hash_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mm3_pkg.sv
rtl/mm3_datapath.sv
rtl/mm3_ctrl.sv
rtl/murmur3_32_stream_hash_core.sv
verif/murmur3_32_stream_hash_core_tb.sv
